[rtl/core/dlsw_pkg.sv]
// ----------------------------------------------------------------------------
// dlsw_pkg: shared types and constants of the dual-lane stop-and-wait core
// Operation and result codes, the configuration bundle, the command that
// travels from the front end to the back end, and the result beat format.
// ----------------------------------------------------------------------------
package dlsw_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;
  localparam int SEQ_W       = 7;
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = 2;
  localparam int RES_CNT_W   = 3;

  localparam logic [7:0]  LANE1_TYPE_MIN    = 8'h10;
  localparam logic [31:0] RESEND_TICKS_INIT = 32'd250;
  localparam logic [7:0]  RESUME_TYPE_INIT  = 8'd16;
  localparam logic [7:0]  DELAY_TYPE_INIT   = 8'd17;
  localparam logic [6:0]  HEADER_INIT       = 7'd6;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_SEND = 3'd1,
    OP_ACK  = 3'd2,
    OP_DATA = 3'd3,
    OP_TAKE = 3'd4,
    OP_SRST = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_XMIT   = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_INLINE = 3'd3,
    KIND_QUEUED = 3'd4,
    KIND_MSG    = 3'd5,
    KIND_EMPTY  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_RESEND_TICKS = 3'd1,
    REG_RESUME_TYPE  = 3'd2,
    REG_DELAY_TYPE   = 3'd3,
    REG_HEADER_BYTES = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        enable;
    logic [31:0] resend_ticks;
    logic [7:0]  resume_type;
    logic [7:0]  delay_type;
    logic [6:0]  header_bytes;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic        lane;
    logic [7:0]  msg_type;
    logic [15:0] msg_len;
    logic [7:0]  wire_seq;
    logic [15:0] max_len;
    logic        len_ok;
    logic        frame_ok;
    logic        inline_type;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic        ok;
    logic        lane;
    logic [7:0]  wire_seq_res;
    logic [7:0]  msg_type_res;
    logic [15:0] msg_len_res;
    logic [1:0]  slot;
    logic [7:0]  resend_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_push_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    logic                 space;
  } res_stat_t;

  typedef struct packed {
    logic        fire;
    logic        sent;
    logic [31:0] elapsed;
    logic [7:0]  resends;
  } svc_t;

  // Resend decision for one lane; the elapsed count only advances on a tick.
  function automatic svc_t service(logic busy, logic sent, logic [31:0] el,
                                   logic [7:0] rs, logic tick, logic [31:0] rt);
    svc_t        s;
    logic [31:0] e;
    e = (tick && el != '1) ? el + 32'd1 : el;
    s.fire    = busy && !(sent && e < rt);
    s.sent    = sent;
    s.elapsed = busy ? e : el;
    s.resends = rs;
    if (s.fire) begin
      s.sent    = 1'b1;
      s.elapsed = '0;
      if (sent && rs != 8'hff) begin
        s.resends = rs + 8'd1;
      end
    end
    return s;
  endfunction

  function automatic res_t mk_res(kind_t kind, logic ok, logic lane, logic [7:0] seq,
                                  logic [7:0] mtype, logic [15:0] len, logic [1:0] slot,
                                  logic [7:0] rs);
    res_t r;
    r.kind         = kind;
    r.ok           = ok;
    r.lane         = lane;
    r.wire_seq_res = seq;
    r.msg_type_res = mtype;
    r.msg_len_res  = len;
    r.slot         = slot;
    r.resend_count = rs;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

[rtl/core/dlsw_in_if.sv]
// ----------------------------------------------------------------------------
// dlsw_in_if: event channel into the stop-and-wait core
// Valid/ready channel carrying one event beat.
// ----------------------------------------------------------------------------
interface dlsw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  msg_type;
  logic [15:0] msg_len;
  logic [7:0]  wire_seq;
  logic [15:0] frame_len;
  logic [15:0] max_len;

  modport source(output valid, op, msg_type, msg_len, wire_seq, frame_len, max_len,
                 input ready);
  modport sink(input valid, op, msg_type, msg_len, wire_seq, frame_len, max_len,
               output ready);
endinterface

[rtl/core/dlsw_out_if.sv]
// ----------------------------------------------------------------------------
// dlsw_out_if: result channel out of the stop-and-wait core
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface dlsw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        ok;
  logic        lane;
  logic [7:0]  wire_seq_res;
  logic [7:0]  msg_type_res;
  logic [15:0] msg_len_res;
  logic [1:0]  slot;
  logic [7:0]  resend_count;
  logic        last;

  modport source(output valid, kind, ok, lane, wire_seq_res, msg_type_res, msg_len_res,
                 slot, resend_count, last, input ready);
  modport sink(input valid, kind, ok, lane, wire_seq_res, msg_type_res, msg_len_res,
               slot, resend_count, last, output ready);
endinterface

[rtl/core/dlsw_front.sv]
// ----------------------------------------------------------------------------
// dlsw_front: event intake and classification
// Accepts event beats, works out the lane and the stateless frame checks,
// and holds classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dlsw_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  dlsw_in_if.sink       in_ch,
  input  dlsw_pkg::cfg_t cfg,
  output logic          cmd_valid,
  output dlsw_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import dlsw_pkg::*;

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  // Ops without a meaning are taken and dropped here.
  assign push = in_ch.valid && in_ch.ready && (in_ch.op <= 3'(OP_SRST));
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop  = cmd_valid && cmd_ready;
  assign cmd  = q_r[rd_ptr_r];

  always_comb begin
    cls.op          = op_t'(in_ch.op);
    cls.lane        = (in_ch.op == 3'(OP_SEND)) ? (in_ch.msg_type >= LANE1_TYPE_MIN)
                                                 : in_ch.wire_seq[7];
    cls.msg_type    = in_ch.msg_type;
    cls.msg_len     = in_ch.msg_len;
    cls.wire_seq    = in_ch.wire_seq;
    cls.max_len     = in_ch.max_len;
    cls.len_ok      = (in_ch.msg_len <= MAX_LEN);
    cls.frame_ok    = (in_ch.msg_len <= MAX_LEN) &&
                      ({1'b0, in_ch.frame_len} >=
                       ({1'b0, in_ch.msg_len} + {10'd0, cfg.header_bytes}));
    cls.inline_type = (in_ch.msg_type == cfg.resume_type) ||
                      (in_ch.msg_type == cfg.delay_type);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[rtl/core/dlsw_back.sv]
// ----------------------------------------------------------------------------
// dlsw_back: lane state and event execution
// Holds the transmit and receive queues and sequence state, executes one
// command per cycle while the result queue has room and hands up to two result beats to it.
// ----------------------------------------------------------------------------
module dlsw_back #(
  parameter int MAX_PAYLOAD  = 256,
  parameter int REACK_WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dlsw_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  input  dlsw_pkg::cmd_t     cmd,
  output logic               cmd_ready,
  input  dlsw_pkg::res_stat_t res_stat,
  output dlsw_pkg::res_push_t res_push
);
  import dlsw_pkg::*;

  localparam int         LEN_W     = $clog2(MAX_PAYLOAD + 1);
  localparam logic [6:0] REACK_MIN = 7'(128 - REACK_WINDOW);

  logic [PTR_W-1:0] tx_head_r [2], tx_head_nxt [2];
  logic [CNT_W-1:0] tx_count_r [2], tx_count_nxt [2];
  logic [SEQ_W-1:0] tx_seq_r [2], tx_seq_nxt [2];
  logic             tx_sent_r [2], tx_sent_nxt [2];
  logic [31:0]      tx_elapsed_r [2], tx_elapsed_nxt [2];
  logic [7:0]       tx_resends_r [2], tx_resends_nxt [2];
  logic [SEQ_W-1:0] rx_expect_r [2], rx_expect_nxt [2];
  logic [PTR_W-1:0] rx_head_r, rx_head_nxt;
  logic [CNT_W-1:0] rx_count_r, rx_count_nxt;

  // Both queues shift toward entry 0, so entry 0 is always the head.
  logic [7:0]       txq_type_r [2][QUEUE_DEPTH], txq_type_nxt [2][QUEUE_DEPTH];
  logic [LEN_W-1:0] txq_len_r [2][QUEUE_DEPTH], txq_len_nxt [2][QUEUE_DEPTH];
  logic [7:0]       rxq_type_r [QUEUE_DEPTH], rxq_type_nxt [QUEUE_DEPTH];
  logic [LEN_W-1:0] rxq_len_r [QUEUE_DEPTH], rxq_len_nxt [QUEUE_DEPTH];

  logic       exec;
  logic [1:0] n_res;
  res_t       r0, r1;

  assign cmd_ready = res_stat.space;
  assign exec      = cmd_valid && cmd_ready;

  always_comb begin
    svc_t        s0, s1, sv;
    res_t        t1;
    logic        l, ok;
    logic [6:0]  dm;
    logic [7:0]  hd_type;
    logic [15:0] hd_len, clip;
    tx_head_nxt    = tx_head_r;
    tx_count_nxt   = tx_count_r;
    tx_seq_nxt     = tx_seq_r;
    tx_sent_nxt    = tx_sent_r;
    tx_elapsed_nxt = tx_elapsed_r;
    tx_resends_nxt = tx_resends_r;
    rx_expect_nxt  = rx_expect_r;
    rx_head_nxt    = rx_head_r;
    rx_count_nxt   = rx_count_r;
    txq_type_nxt   = txq_type_r;
    txq_len_nxt    = txq_len_r;
    rxq_type_nxt   = rxq_type_r;
    rxq_len_nxt    = rxq_len_r;
    n_res = 2'd0;
    r0    = '0;
    r1    = '0;
    l     = cmd.lane;
    ok    = 1'b0;
    dm    = cmd.wire_seq[6:0] - rx_expect_r[l];
    s0    = service(tx_count_r[0] != '0, tx_sent_r[0], tx_elapsed_r[0], tx_resends_r[0],
                    1'b1, cfg.resend_ticks);
    s1    = service(tx_count_r[1] != '0, tx_sent_r[1], tx_elapsed_r[1], tx_resends_r[1],
                    1'b1, cfg.resend_ticks);
    sv    = service(1'b1, tx_sent_r[l], tx_elapsed_r[l], tx_resends_r[l], 1'b0,
                    cfg.resend_ticks);
    t1    = '0;
    hd_type = (tx_count_r[l] == '0) ? cmd.msg_type : txq_type_r[l][0];
    hd_len  = (tx_count_r[l] == '0) ? cmd.msg_len : 16'(txq_len_r[l][0]);
    clip    = (16'(rxq_len_r[0]) > cmd.max_len) ? cmd.max_len : 16'(rxq_len_r[0]);

    case (cmd.op)
      OP_TICK: begin
        tx_sent_nxt[0]    = s0.sent;
        tx_elapsed_nxt[0] = s0.elapsed;
        tx_resends_nxt[0] = s0.resends;
        tx_sent_nxt[1]    = s1.sent;
        tx_elapsed_nxt[1] = s1.elapsed;
        tx_resends_nxt[1] = s1.resends;
        if (s0.fire) begin
          r0 = mk_res(KIND_XMIT, 1'b0, 1'b0, {1'b0, tx_seq_r[0]}, txq_type_r[0][0],
                      16'(txq_len_r[0][0]), tx_head_r[0], s0.resends);
        end
        t1 = mk_res(KIND_XMIT, 1'b0, 1'b1, {1'b1, tx_seq_r[1]}, txq_type_r[1][0],
                    16'(txq_len_r[1][0]), tx_head_r[1], s1.resends);
        if (s1.fire) begin
          if (s0.fire) begin
            r1 = t1;
          end else begin
            r0 = t1;
          end
        end
        n_res = {1'b0, s0.fire} + {1'b0, s1.fire};
      end
      OP_SEND: begin
        ok    = cfg.enable && cmd.len_ok && (tx_count_r[l] < CNT_W'(QUEUE_DEPTH));
        r0    = mk_res(KIND_STATUS, ok, l, 8'd0, 8'd0, 16'd0, 2'd0, 8'd0);
        n_res = 2'd1;
        if (ok) begin
          txq_type_nxt[l][tx_count_r[l][PTR_W-1:0]] = cmd.msg_type;
          txq_len_nxt[l][tx_count_r[l][PTR_W-1:0]]  = cmd.msg_len[LEN_W-1:0];
          tx_count_nxt[l]   = tx_count_r[l] + CNT_W'(1);
          tx_sent_nxt[l]    = sv.sent;
          tx_elapsed_nxt[l] = sv.elapsed;
          tx_resends_nxt[l] = sv.resends;
          if (sv.fire) begin
            // An empty queue means the new entry is the head being sent.
            r1 = mk_res(KIND_XMIT, 1'b0, l, {l, tx_seq_r[l]}, hd_type, hd_len,
                        tx_head_r[l], sv.resends);
            n_res = 2'd2;
          end
        end
      end
      OP_ACK: begin
        if (tx_count_r[l] != '0 && cmd.wire_seq[6:0] == tx_seq_r[l]) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            txq_type_nxt[l][i] = txq_type_r[l][i+1];
            txq_len_nxt[l][i]  = txq_len_r[l][i+1];
          end
          tx_head_nxt[l]    = tx_head_r[l] + PTR_W'(1);
          tx_count_nxt[l]   = tx_count_r[l] - CNT_W'(1);
          tx_seq_nxt[l]     = tx_seq_r[l] + SEQ_W'(1);
          tx_sent_nxt[l]    = 1'b0;
          tx_elapsed_nxt[l] = '0;
          tx_resends_nxt[l] = '0;
          if (tx_count_r[l] > CNT_W'(1)) begin
            r0 = mk_res(KIND_XMIT, 1'b0, l, {l, tx_seq_r[l] + SEQ_W'(1)}, txq_type_r[l][1],
                        16'(txq_len_r[l][1]), tx_head_r[l] + PTR_W'(1), 8'd0);
            tx_sent_nxt[l] = 1'b1;
            n_res = 2'd1;
          end
        end
      end
      OP_DATA: begin
        if (cmd.frame_ok) begin
          r1 = mk_res(KIND_ACK, 1'b0, l, cmd.wire_seq, 8'd0, 16'd0, 2'd0, 8'd0);
          if (dm == 7'd0) begin
            if (!l || cmd.inline_type) begin
              r0 = mk_res(KIND_INLINE, 1'b0, l, cmd.wire_seq, cmd.msg_type, cmd.msg_len,
                          2'd0, 8'd0);
              rx_expect_nxt[l] = rx_expect_r[l] + SEQ_W'(1);
              n_res = 2'd2;
            end else if (rx_count_r < CNT_W'(QUEUE_DEPTH)) begin
              rxq_type_nxt[rx_count_r[PTR_W-1:0]] = cmd.msg_type;
              rxq_len_nxt[rx_count_r[PTR_W-1:0]]  = cmd.msg_len[LEN_W-1:0];
              rx_count_nxt = rx_count_r + CNT_W'(1);
              r0 = mk_res(KIND_QUEUED, 1'b0, l, cmd.wire_seq, cmd.msg_type, cmd.msg_len,
                          rx_head_r + rx_count_r[PTR_W-1:0], 8'd0);
              rx_expect_nxt[l] = rx_expect_r[l] + SEQ_W'(1);
              n_res = 2'd2;
            end
          end else if (dm >= REACK_MIN) begin
            // A frame a little behind the expected one is acked again.
            r0    = r1;
            n_res = 2'd1;
          end
        end
      end
      OP_TAKE: begin
        n_res = 2'd1;
        if (rx_count_r == '0) begin
          r0 = mk_res(KIND_EMPTY, 1'b0, 1'b1, 8'd0, 8'd0, 16'd0, 2'd0, 8'd0);
        end else begin
          r0 = mk_res(KIND_MSG, 1'b0, 1'b1, 8'd0, rxq_type_r[0], clip, rx_head_r, 8'd0);
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            rxq_type_nxt[i] = rxq_type_r[i+1];
            rxq_len_nxt[i]  = rxq_len_r[i+1];
          end
          rx_head_nxt  = rx_head_r + PTR_W'(1);
          rx_count_nxt = rx_count_r - CNT_W'(1);
        end
      end
      OP_SRST: begin
        for (int j = 0; j < 2; j++) begin
          tx_head_nxt[j]    = '0;
          tx_count_nxt[j]   = '0;
          tx_seq_nxt[j]     = '0;
          tx_sent_nxt[j]    = 1'b0;
          tx_elapsed_nxt[j] = '0;
          tx_resends_nxt[j] = '0;
          rx_expect_nxt[j]  = '0;
        end
        rx_head_nxt  = '0;
        rx_count_nxt = '0;
      end
      default: begin
        n_res = 2'd0;
      end
    endcase

    if (n_res == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_comb begin
    res_push.n  = exec ? n_res : 2'd0;
    res_push.r0 = r0;
    res_push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 2; j++) begin
        tx_head_r[j]    <= '0;
        tx_count_r[j]   <= '0;
        tx_seq_r[j]     <= '0;
        tx_sent_r[j]    <= 1'b0;
        tx_elapsed_r[j] <= '0;
        tx_resends_r[j] <= '0;
        rx_expect_r[j]  <= '0;
      end
      rx_head_r  <= '0;
      rx_count_r <= '0;
    end else if (exec) begin
      tx_head_r    <= tx_head_nxt;
      tx_count_r   <= tx_count_nxt;
      tx_seq_r     <= tx_seq_nxt;
      tx_sent_r    <= tx_sent_nxt;
      tx_elapsed_r <= tx_elapsed_nxt;
      tx_resends_r <= tx_resends_nxt;
      rx_expect_r  <= rx_expect_nxt;
      rx_head_r    <= rx_head_nxt;
      rx_count_r   <= rx_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      txq_type_r <= txq_type_nxt;
      txq_len_r  <= txq_len_nxt;
      rxq_type_r <= rxq_type_nxt;
      rxq_len_r  <= rxq_len_nxt;
    end
  end

endmodule

[rtl/core/dlsw_res_fifo.sv]
// ----------------------------------------------------------------------------
// dlsw_res_fifo: result queue
// Takes up to two result beats per cycle from the back end and presents
// them one beat at a time on the result channel.
// ----------------------------------------------------------------------------
module dlsw_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  dlsw_pkg::res_push_t res_push,
  output dlsw_pkg::res_stat_t res_stat,
  dlsw_out_if.source          out_ch
);
  import dlsw_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;
  res_t                 head;

  assign head         = mem_r[rd_ptr_r];
  assign out_ch.valid = (cnt_r != '0);
  assign pop          = out_ch.valid && out_ch.ready;

  assign out_ch.kind         = 3'(head.kind);
  assign out_ch.ok           = head.ok;
  assign out_ch.lane         = head.lane;
  assign out_ch.wire_seq_res = head.wire_seq_res;
  assign out_ch.msg_type_res = head.msg_type_res;
  assign out_ch.msg_len_res  = head.msg_len_res;
  assign out_ch.slot         = head.slot;
  assign out_ch.resend_count = head.resend_count;
  assign out_ch.last         = head.last;

  // Room for a full pair is judged on the registered count alone.
  assign res_stat.count = cnt_r;
  assign res_stat.space = (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(res_push.n);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(res_push.n) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= res_push.r0;
    end
    if (res_push.n == 2'd2) begin
      mem_r[wr_ptr_r + RES_PTR_W'(1)] <= res_push.r1;
    end
  end

endmodule

[rtl/core/dual_lane_stop_and_wait_arq_core.sv]
// ----------------------------------------------------------------------------
// dual_lane_stop_and_wait_arq_core: two-lane stop-and-wait reliable channel
// Event beats enter on in_ch (tick, send, ack, data frame, take, session
// reset). Result beats leave on out_ch; each event yields zero, one or two
// beats, and the final beat of an event has last set.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Writes to unused indexes are ignored. An accepted event beat is registered
// in the command queue and its result beats in the result queue before they
// are valid on out_ch. The back end executes one event per cycle when the
// result queue has room for two beats; the result port drains one beat per
// cycle while out_ch.ready is high.
// A two-entry command queue keeps in_ch ready while the receiver stalls;
// the back end waits once the four-beat result queue holds three or more
// beats, and when the command queue is full as well, in_ch.ready drops.
// Reset clears all lane state and both queues and loads the register
// defaults; queue payload stores are not cleared, as an entry is only read
// after it has been written.
// ----------------------------------------------------------------------------
module dual_lane_stop_and_wait_arq_core #(
  parameter int MAX_PAYLOAD  = 256,
  parameter int REACK_WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  dlsw_in_if.sink     in_ch,
  dlsw_out_if.source  out_ch
);
  import dlsw_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      cmd_valid, cmd_ready;
  cmd_t      cmd;
  res_push_t res_push;
  res_stat_t res_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       cfg_nxt.enable       = cfg_wdata[0];
        REG_RESEND_TICKS: cfg_nxt.resend_ticks = cfg_wdata;
        REG_RESUME_TYPE:  cfg_nxt.resume_type  = cfg_wdata[7:0];
        REG_DELAY_TYPE:   cfg_nxt.delay_type   = cfg_wdata[7:0];
        REG_HEADER_BYTES: cfg_nxt.header_bytes = cfg_wdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.resend_ticks <= RESEND_TICKS_INIT;
      cfg_r.resume_type  <= RESUME_TYPE_INIT;
      cfg_r.delay_type   <= DELAY_TYPE_INIT;
      cfg_r.header_bytes <= HEADER_INIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dlsw_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  dlsw_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .REACK_WINDOW(REACK_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .res_stat  (res_stat),
    .res_push  (res_push)
  );

  dlsw_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_stat (res_stat),
    .out_ch   (out_ch)
  );

  // The result queue never holds more beats than it has entries.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_stat.count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // A command the back end cannot take stays pending for the next cycle.
  a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !cmd_ready) |=> cmd_valid)
    else $error("stalled command lost");

  // Results are only pushed when the queue has room for a full pair.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push.n != 2'd0) |-> res_stat.space)
    else $error("result push without room");

  // Coming out of reset no result beat is offered.
  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
